/* rtl/core/mbd5_pkg.sv */
// ----------------------------------------------------------------------------
// mbd5_pkg: shared types and constants of the degree-5 multibrot unit
// Holds the controller states, the multiply step codes, the command and status
// structs that join the controller and the datapath, and the register indexes.
// ----------------------------------------------------------------------------
package mbd5_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 28;
  localparam int LIMIT_FRAC      = 24;
  localparam int LIMIT_W         = 32;
  localparam int COUNT_W         = 16;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ITER_CAP     = 1'd1;

  localparam logic [LIMIT_W-1:0] ESCAPE_LIMIT_RST = 32'd67108864;
  localparam logic [COUNT_W-1:0] ITER_CAP_RST     = 16'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DRAIN,
    ST_COMB,
    ST_UPD,
    ST_DONE
  } ctrl_state_t;

  // Issue order keeps every operand at least two steps ahead of its use.
  typedef enum logic [3:0] {
    M_XX,
    M_YY,
    M_X3,
    M_Y3,
    M_X4,
    M_Y4,
    M_X5,
    M_Y5,
    M_T,
    M_U,
    M_V,
    M_W
  } mul_step_t;

  typedef struct packed {
    logic      start;
    logic      issue;
    mul_step_t step;
    logic      comb;
    logic      update;
    logic      load_out;
  } mbd5_cmd_t;

  typedef struct packed {
    logic cont;
  } mbd5_status_t;

endpackage

/* rtl/core/multibrot_degree5_escape_count_unit.sv */
// ----------------------------------------------------------------------------
// multibrot_degree5_escape_count_unit: escape-time counter for z -> z^5 + c
// A point makes N passes; one pass is twelve issues of the shared multiplier
// plus drain, combine, update and check. One point is in work at a time, so
// a request is taken only once the previous point is done; the finished count
// waits in an output register, so the next request is taken while the result
// is still unread.
// Reset (rst, synchronous, active high) sets escape_limit to 4.0, max_iterations
// to 256 and empties the output.
// ----------------------------------------------------------------------------
module multibrot_degree5_escape_count_unit #(
  parameter int COORD_WIDTH = mbd5_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbd5_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes: index 0 escape_limit, index 1 max_iterations.
  input  logic                             cfg_we,
  input  logic [mbd5_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbd5_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Request stream: tdata holds c_re (lowest bits), then c_im, zero padded.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // Result stream: tdata holds iteration_count.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mbd5_pkg::COUNT_W-1:0]     m_tdata
);

  mbd5_pkg::mbd5_cmd_t    cmd;
  mbd5_pkg::mbd5_status_t status;

  // The controller sequences passes; the datapath holds all arithmetic state.
  mbd5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbd5_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .c_re            (s_tdata[COORD_WIDTH-1:0]),
    .c_im            (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .cmd             (cmd),
    .status          (status),
    .iteration_count (m_tdata)
  );

endmodule

/* rtl/core/mbd5_ctrl.sv */
// ----------------------------------------------------------------------------
// mbd5_ctrl: sequencer of the degree-5 multibrot unit
// Steps the shared multiplier through one pass and decides on further passes.
// ----------------------------------------------------------------------------
module mbd5_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  mbd5_pkg::mbd5_status_t status,
  output mbd5_pkg::mbd5_cmd_t    cmd
);

  mbd5_pkg::ctrl_state_t state, state_next;
  mbd5_pkg::mul_step_t   step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mbd5_pkg::ST_IDLE;
      step     <= mbd5_pkg::M_XX;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mbd5_pkg::ST_MUL) begin
        step <= mbd5_pkg::mul_step_t'(step + 4'd1);
      end else begin
        step <= mbd5_pkg::M_XX;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.step     = step;
    s_tready     = 1'b0;
    case (state)
      mbd5_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = mbd5_pkg::ST_CHECK;
        end
      end
      mbd5_pkg::ST_CHECK: begin
        state_next = status.cont ? mbd5_pkg::ST_MUL : mbd5_pkg::ST_DONE;
      end
      mbd5_pkg::ST_MUL: begin
        cmd.issue = 1'b1;
        if (step == mbd5_pkg::M_W) begin
          state_next = mbd5_pkg::ST_DRAIN;
        end
      end
      mbd5_pkg::ST_DRAIN: begin
        state_next = mbd5_pkg::ST_COMB;
      end
      mbd5_pkg::ST_COMB: begin
        cmd.comb   = 1'b1;
        state_next = mbd5_pkg::ST_UPD;
      end
      mbd5_pkg::ST_UPD: begin
        cmd.update = 1'b1;
        state_next = mbd5_pkg::ST_CHECK;
      end
      mbd5_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = mbd5_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbd5_pkg::ST_IDLE;
      end
    endcase
  end

  a_start_to_check: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == mbd5_pkg::ST_CHECK))
    else $error("accepted request did not start a check");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == mbd5_pkg::ST_MUL) |-> (step <= mbd5_pkg::M_W))
    else $error("multiply step out of range");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (m_tvalid && state == mbd5_pkg::ST_IDLE))
    else $error("result load did not present a result");

endmodule

/* rtl/core/mbd5_datapath.sv */
// ----------------------------------------------------------------------------
// mbd5_datapath: arithmetic of the degree-5 multibrot unit
// One shared saturating fixed-point multiplier, the power and cross-term
// registers, the saturating combine, the magnitude check and the count.
// ----------------------------------------------------------------------------
module mbd5_datapath #(
  parameter int COORD_WIDTH = mbd5_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbd5_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mbd5_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbd5_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_WIDTH-1:0]       c_re,
  input  logic signed [COORD_WIDTH-1:0]       c_im,
  input  mbd5_pkg::mbd5_cmd_t                 cmd,
  output mbd5_pkg::mbd5_status_t              status,
  output logic [mbd5_pkg::COUNT_W-1:0]        iteration_count
);

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2 * W;
  localparam int LSH = 2 * FRAC_BITS - mbd5_pkg::LIMIT_FRAC;
  localparam int LW  = mbd5_pkg::LIMIT_W + LSH;
  localparam int RW  = ((PW + 1) > LW) ? (PW + 1) : LW;

  logic [mbd5_pkg::LIMIT_W-1:0] escape_limit;
  logic [mbd5_pkg::COUNT_W-1:0] max_iterations;
  logic [mbd5_pkg::COUNT_W-1:0] n;

  logic signed [W-1:0] cr, ci, x, y;
  logic signed [W-1:0] x2, x3, x4, x5, y2, y3, y4, y5, t, u, v, w;
  logic signed [W-1:0] re_part, im_part;
  logic [PW-1:0]       rx;
  logic [PW:0]         r;

  logic signed [W-1:0] op_a, op_b;
  logic [W-1:0]        mag_a, mag_b;
  logic [PW-1:0]       p;
  logic                neg;
  logic                wb_valid;
  mbd5_pkg::mul_step_t wb_step;

  logic [PW-1:0]       shifted;
  logic [W-1:0]        lim_mag, fm_mag;
  logic signed [W-1:0] fm;

  function automatic logic signed [W-1:0] sat(input logic signed [W+3:0] val);
    logic signed [W+3:0] hi_bound;
    logic signed [W+3:0] lo_bound;
    hi_bound = {5'b00000, {(W-1){1'b1}}};
    lo_bound = {5'b11111, {(W-1){1'b0}}};
    if (val > hi_bound) begin
      return hi_bound[W-1:0];
    end else if (val < lo_bound) begin
      return lo_bound[W-1:0];
    end
    return val[W-1:0];
  endfunction

  function automatic logic signed [W+3:0] ext(input logic signed [W-1:0] a);
    return {{4{a[W-1]}}, a};
  endfunction

  // Operand selection for the step being issued.
  always_comb begin
    case (cmd.step)
      mbd5_pkg::M_XX: begin op_a = x;  op_b = x; end
      mbd5_pkg::M_YY: begin op_a = y;  op_b = y; end
      mbd5_pkg::M_X3: begin op_a = x2; op_b = x; end
      mbd5_pkg::M_Y3: begin op_a = y2; op_b = y; end
      mbd5_pkg::M_X4: begin op_a = x3; op_b = x; end
      mbd5_pkg::M_Y4: begin op_a = y3; op_b = y; end
      mbd5_pkg::M_X5: begin op_a = x4; op_b = x; end
      mbd5_pkg::M_Y5: begin op_a = y4; op_b = y; end
      mbd5_pkg::M_T:  begin op_a = x3; op_b = y2; end
      mbd5_pkg::M_U:  begin op_a = x;  op_b = y4; end
      mbd5_pkg::M_V:  begin op_a = x4; op_b = y; end
      mbd5_pkg::M_W:  begin op_a = x2; op_b = y3; end
      default:        begin op_a = x;  op_b = x; end
    endcase
  end

  assign mag_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;

  // Post-processing of the registered product: truncate, saturate, resign.
  assign shifted = p >> FRAC_BITS;
  assign lim_mag = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg};
  assign fm_mag  = (shifted > {{W{1'b0}}, lim_mag}) ? lim_mag : shifted[W-1:0];
  assign fm      = neg ? (~fm_mag + 1'b1) : fm_mag;

  // Combine terms of the new point.
  logic signed [W-1:0] re1, re2, im1, im2, t10, u5, v5, w10;
  always_comb begin
    t10 = sat((ext(t) <<< 3) + (ext(t) <<< 1));
    w10 = sat((ext(w) <<< 3) + (ext(w) <<< 1));
    u5  = sat((ext(u) <<< 2) + ext(u));
    v5  = sat((ext(v) <<< 2) + ext(v));
    re1 = sat(ext(x5) - ext(t10));
    re2 = sat(ext(re1) + ext(u5));
    im1 = sat(ext(v5) - ext(w10));
    im2 = sat(ext(im1) + ext(y5));
  end

  logic [RW-1:0] r_ext, lim_ext;
  assign r_ext   = RW'(r);
  assign lim_ext = RW'(escape_limit) << LSH;
  assign status.cont = (r_ext < lim_ext) && (n < max_iterations);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_limit   <= mbd5_pkg::ESCAPE_LIMIT_RST;
      max_iterations <= mbd5_pkg::ITER_CAP_RST;
      wb_valid       <= 1'b0;
    end else begin
      wb_valid <= cmd.issue;
      if (cfg_we) begin
        case (cfg_index)
          mbd5_pkg::REG_ESCAPE_LIMIT: escape_limit <= cfg_data;
          mbd5_pkg::REG_ITER_CAP:     max_iterations <= cfg_data[mbd5_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p       <= mag_a * mag_b;
    neg     <= op_a[W-1] ^ op_b[W-1];
    wb_step <= cmd.step;
    if (wb_valid) begin
      case (wb_step)
        mbd5_pkg::M_XX: begin x2 <= fm; rx <= p; end
        mbd5_pkg::M_YY: begin y2 <= fm; r <= {1'b0, rx} + {1'b0, p}; end
        mbd5_pkg::M_X3: x3 <= fm;
        mbd5_pkg::M_Y3: y3 <= fm;
        mbd5_pkg::M_X4: x4 <= fm;
        mbd5_pkg::M_Y4: y4 <= fm;
        mbd5_pkg::M_X5: x5 <= fm;
        mbd5_pkg::M_Y5: y5 <= fm;
        mbd5_pkg::M_T:  t  <= fm;
        mbd5_pkg::M_U:  u  <= fm;
        mbd5_pkg::M_V:  v  <= fm;
        mbd5_pkg::M_W:  w  <= fm;
        default: ;
      endcase
    end
    if (cmd.comb) begin
      re_part <= re2;
      im_part <= im2;
    end
    if (cmd.start) begin
      cr <= c_re;
      ci <= c_im;
      x  <= '0;
      y  <= '0;
      r  <= '0;
      n  <= '0;
    end else if (cmd.update) begin
      x <= sat(ext(re_part) + ext(cr));
      y <= sat(ext(im_part) + ext(ci));
      n <= n + 1'b1;
    end
    if (cmd.load_out) begin
      iteration_count <= n;
    end
  end

endmodule

/* tb/sv/multibrot_degree5_escape_count_unit_tb.sv */
// ----------------------------------------------------------------------------
// multibrot_degree5_escape_count_unit_tb: self-checking bench of the escape counter
// A short table of directed points and settings comes first. Random points
// under several register settings and three idling patterns follow. Every
// returned count is compared with a bit-true fixed-point predictor.
// ----------------------------------------------------------------------------
module multibrot_degree5_escape_count_unit_tb;

  localparam int FB = 28;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;
  localparam int NO_EXP = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mbd5_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mbd5_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;  // c_re [31:0], c_im [63:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mbd5_pkg::COUNT_W-1:0] m_tdata;  // iteration_count [15:0]

  multibrot_degree5_escape_count_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies kept by the bench; they follow every write we make.
  logic [31:0] cur_limit = mbd5_pkg::ESCAPE_LIMIT_RST;
  logic [15:0] cur_iter_cap = mbd5_pkg::ITER_CAP_RST;

  logic [15:0] expected_counts[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_off = 1'b0;

  // Saturate to the signed coordinate range.
  function automatic longint clamp(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Product rounded toward zero on its magnitude, then saturated. The
  // negative side may reach one more than the positive side.
  function automatic longint fx_mul(longint a, longint b);
    logic neg;
    logic [63:0] q;
    logic [63:0] lim;
    neg = (a < 0) != (b < 0);
    q = (mag(a) * mag(b)) >> FB;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Number of passes the unit makes for point c under the given settings.
  function automatic logic [15:0] predict_count(logic [31:0] c_re, logic [31:0] c_im,
                                                logic [31:0] limit, logic [15:0] iter_cap);
    longint x, y, cr, ci, x2, x3, x4, x5, y2, y3, y4, y5, re, im;
    logic [63:0] r, lim;
    int n;
    cr = longint'($signed(c_re));
    ci = longint'($signed(c_im));
    x = 0;
    y = 0;
    r = 0;
    n = 0;
    // The limit is Q8.24; r carries twice the coordinate fraction bits.
    lim = {32'd0, limit} << (2 * FB - mbd5_pkg::LIMIT_FRAC);
    while (r < lim && n < iter_cap) begin
      x2 = fx_mul(x, x);   x3 = fx_mul(x2, x);
      x4 = fx_mul(x3, x);  x5 = fx_mul(x4, x);
      y2 = fx_mul(y, y);   y3 = fx_mul(y2, y);
      y4 = fx_mul(y3, y);  y5 = fx_mul(y4, y);
      r = mag(x) * mag(x) + mag(y) * mag(y);
      // Repeated saturating addition of one value equals a clamped multiple.
      re = clamp(x5 - clamp(10 * fx_mul(x3, y2)));
      re = clamp(re + clamp(5 * fx_mul(x, y4)));
      re = clamp(re + cr);
      im = clamp(clamp(5 * fx_mul(x4, y)) - clamp(10 * fx_mul(x2, y3)));
      im = clamp(im + y5);
      im = clamp(im + ci);
      x = re;
      y = im;
      n++;
    end
    return n[15:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Result side: check each accepted count against the oldest expectation,
  // then choose tready for the next cycle. While a hold-off runs, tready
  // stays low and the sender keeps offering requests.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, 0);
        end else begin
          if (m_tdata !== expected_counts[0])
            report_mismatch("iteration_count", m_tdata, expected_counts[0]);
          void'(expected_counts.pop_front());
        end
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    while (expected_counts.size() != 0 || hold_off) @(posedge clk);
  endtask

  // Register writes happen only with nothing in flight and nothing offered.
  task automatic write_reg(logic [mbd5_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
    s_tvalid <= 1'b0;
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mbd5_pkg::REG_ESCAPE_LIMIT) cur_limit = value;
    else cur_iter_cap = value[15:0];
  endtask

  task automatic set_config(logic [31:0] limit, logic [15:0] iter_cap);
    if (limit !== cur_limit) write_reg(mbd5_pkg::REG_ESCAPE_LIMIT, limit);
    if (iter_cap !== cur_iter_cap) write_reg(mbd5_pkg::REG_ITER_CAP, {16'd0, iter_cap});
  endtask

  // Offer one request; valid stays high from one request to the next unless
  // a random gap lowers it.
  task automatic send_point(logic [31:0] c_re, logic [31:0] c_im, int want);
    logic [15:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c_im, c_re};
    do @(posedge clk); while (!s_tready);
    pred = predict_count(c_re, c_im, cur_limit, cur_iter_cap);
    if (want != NO_EXP && pred != want) report_mismatch("predictor vs table", pred, want);
    expected_counts.push_back(pred);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  typedef struct {
    logic [31:0] limit;
    logic [15:0] iter_cap;
    logic [31:0] c_re;
    logic [31:0] c_im;
    int want;
  } dir_row_t;

  // Directed rows. Counts are typed in only where they are obvious: the origin
  // never escapes, a point of magnitude near 8 escapes on the second pass, a
  // zero limit or a zero cap makes no pass, and an unreachable limit runs to
  // the cap.
  dir_row_t dir_rows[] = '{
    '{32'd67108864, 16'd256, 32'h0000_0000, 32'h0000_0000, 256},
    '{32'd67108864, 16'd256, 32'h7FFF_FFFF, 32'h0000_0000, 2},
    '{32'd67108864, 16'd256, 32'h8000_0000, 32'h0000_0000, 2},
    '{32'd67108864, 16'd256, 32'h0000_0000, 32'h7FFF_FFFF, 2},
    '{32'd67108864, 16'd256, 32'h0000_0000, 32'h8000_0000, 2},
    '{32'd67108864, 16'd256, 32'h8000_0000, 32'h8000_0000, 2},
    '{32'd67108864, 16'd256, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2},
    '{32'd67108864, 16'd256, 32'hF000_0000, 32'h0000_0000, NO_EXP},
    '{32'd67108864, 16'd256, 32'h0800_0000, 32'h0C00_0000, NO_EXP},
    '{32'd67108864, 16'd256, 32'hF400_0000, 32'h0200_0000, NO_EXP},
    '{32'd0,        16'd256, 32'h1234_5678, 32'h8765_4321, 0},
    '{32'd0,        16'd256, 32'h0000_0000, 32'h0000_0000, 0},
    '{32'd67108864, 16'd0,   32'h1000_0000, 32'h0000_0000, 0},
    '{32'd67108864, 16'd1,   32'h0000_0000, 32'h0000_0000, 1},
    '{32'hFFFF_FFFF, 16'd20, 32'h7FFF_FFFF, 32'h8000_0000, 20},
    '{32'hFFFF_FFFF, 16'd20, 32'h8000_0000, 32'h7FFF_FFFF, 20},
    '{32'hFFFF_FFFF, 16'd20, 32'h0400_0000, 32'hFA00_0000, 20},
    '{32'd67108864, 16'd65535, 32'h7FFF_FFFF, 32'h0000_0000, 2},
    '{32'd67108864, 16'd65535, 32'h2000_0000, 32'h2000_0000, NO_EXP},
    '{32'h0100_0000, 16'd64, 32'h0A00_0000, 32'h0000_0000, NO_EXP},
    '{32'h0100_0000, 16'd64, 32'hFC00_0000, 32'h0300_0000, NO_EXP}
  };

  // Random points: a third use the full coordinate range, the rest lie
  // within about +-2.0 where counts vary the most.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(2) == 0) return $urandom();
    return $urandom_range(32'h4000_0000) - 32'h2000_0000;
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(32'h0800_0000);
    endcase
  endfunction

  initial begin
    int mode;
    int setting;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      set_config(dir_rows[i].limit, dir_rows[i].iter_cap);
      send_point(dir_rows[i].c_re, dir_rows[i].c_im, dir_rows[i].want);
    end
    stop_sending();

    // Three idling patterns, each with several register settings.
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 47 : 0;
      recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 32 : 0;
      for (setting = 0; setting < 5; setting++) begin
        wait_drained();
        set_config(rand_limit(), 16'($urandom_range(32, 1)));
        // Once, hold the receiver off long enough that the unit fills up and
        // stalls its request side while requests keep coming.
        if (mode == 1 && setting == 0) begin
          fork
            begin
              hold_off <= 1'b1;
              repeat (3000) @(posedge clk);
              hold_off <= 1'b0;
            end
          join_none
        end
        for (k = 0; k < 40; k++) send_point(rand_coord(), rand_coord(), NO_EXP);
        stop_sending();
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
